/* rtl/tprs_pkg.sv */
package tprs_pkg;

    // raw pixel bits that take part in the scaling (8 to 16)
    localparam int PIXEL_BITS = 16;
    localparam int OUT_BITS   = 8;
    // quotient carries one bit above the output range to flag saturation
    localparam int Q_W        = OUT_BITS + 1;
    localparam int N_CELLS    = Q_W;
    // partial remainder: numerator is below 2^(PIXEL_BITS+OUT_BITS), one spare bit for the shift
    localparam int REM_W      = PIXEL_BITS + OUT_BITS + 1;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX = CFG_IDX_W'(1);

    typedef struct packed {
        logic                  vld;
        logic [REM_W-1:0]      rem;
        logic [Q_W-1:0]        q;
        logic [PIXEL_BITS-1:0] span;
    } cell_t;

endpackage

/* rtl/tprs_front.sv */
module tprs_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_vld,
    input  logic [tprs_pkg::PIXEL_BITS-1:0]     pix,
    input  logic [tprs_pkg::PIXEL_BITS-1:0]     lo,
    input  logic [tprs_pkg::PIXEL_BITS-1:0]     hi,
    output tprs_pkg::cell_t                     dout
);

    logic                              a_vld_reg,  a_vld_next;
    logic [tprs_pkg::PIXEL_BITS-1:0]   a_diff_reg, a_diff_next;
    logic [tprs_pkg::PIXEL_BITS-1:0]   a_span_reg, a_span_next;
    tprs_pkg::cell_t                   b_reg, b_next;

    // stage a: difference and divisor, forced so that a pixel at or below range_min, or an inverted range, gives 0
    always_comb begin
        a_vld_next = in_vld;
        if (hi >= lo && pix > lo) begin
            a_diff_next = pix - lo;
        end else begin
            a_diff_next = '0;
        end
        if (hi > lo) begin
            a_span_next = hi - lo;
        end else begin
            a_span_next = tprs_pkg::PIXEL_BITS'(1);
        end
    end

    // stage b: numerator = diff * 255 as (diff << 8) - diff
    always_comb begin
        b_next.vld  = a_vld_reg;
        b_next.rem  = {1'b0, a_diff_reg, {tprs_pkg::OUT_BITS{1'b0}}}
                      - tprs_pkg::REM_W'(a_diff_reg);
        b_next.q    = '0;
        b_next.span = a_span_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_diff_reg  <= a_diff_next;
            a_span_reg  <= a_span_next;
            b_reg.rem   <= b_next.rem;
            b_reg.q     <= b_next.q;
            b_reg.span  <= b_next.span;
        end
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_reg.vld <= 1'b0;
        end else if (en) begin
            a_vld_reg <= a_vld_next;
            b_reg.vld <= b_next.vld;
        end
    end

    assign dout = b_reg;

endmodule

/* rtl/tprs_cell.sv */
module tprs_cell (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  tprs_pkg::cell_t  din,
    output tprs_pkg::cell_t  dout
);

    logic [tprs_pkg::REM_W-1:0] dsh;
    logic [tprs_pkg::REM_W-1:0] rem_sub;
    logic                       ge;
    tprs_pkg::cell_t            c_reg, c_next;

    // one restoring step: divisor sits fixed at span << 8, the remainder moves up
    always_comb begin
        dsh     = {1'b0, din.span, {tprs_pkg::OUT_BITS{1'b0}}};
        ge      = (din.rem >= dsh);
        rem_sub = ge ? (din.rem - dsh) : din.rem;
        c_next.vld  = din.vld;
        c_next.rem  = {rem_sub[tprs_pkg::REM_W-2:0], 1'b0};
        c_next.q    = {din.q[tprs_pkg::Q_W-2:0], ge};
        c_next.span = din.span;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_reg.rem  <= c_next.rem;
            c_reg.q    <= c_next.q;
            c_reg.span <= c_next.span;
        end
        if (!aresetn) begin
            c_reg.vld <= 1'b0;
        end else if (en) begin
            c_reg.vld <= c_next.vld;
        end
    end

    assign dout = c_reg;

endmodule

/* rtl/thermal_pixel_range_scaler.sv */
// channel   direction  handshake             payload
// s_        in         s_tvalid / s_tready   s_tdata[15:0] raw_pixel
// m_        out        m_tvalid / m_tready   m_tdata[7:0]  scaled_pixel
// cfg_      in         cfg_valid / cfg_ready cfg_index (0 range_min, 1 range_max), cfg_data
//
// one pixel per clock while the output is not stalled; each pixel passes through
// two front stages, nine divider cells each settling one quotient bit, and an output register
// aresetn is synchronous, active low; range_min resets to 0, range_max to 65535
// the whole pipeline holds while m_tvalid is high and m_tready low, and s_tready drops with it
// cfg_ready is always high
module thermal_pixel_range_scaler (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [15:0]                         s_tdata,    // [15:0] raw_pixel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,    // [7:0] scaled_pixel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tprs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tprs_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [tprs_pkg::CFG_DATA_W-1:0]  range_min_reg;
    logic [tprs_pkg::CFG_DATA_W-1:0]  range_max_reg;
    logic                             m_vld_reg;
    logic [tprs_pkg::OUT_BITS-1:0]    m_data_reg, m_data_next;
    logic                             adv;
    tprs_pkg::cell_t                  chain [0:tprs_pkg::N_CELLS];

    assign adv       = !m_vld_reg || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_min_reg <= '0;
            range_max_reg <= '1;
        end else if (cfg_valid) begin
            case (cfg_index)
                tprs_pkg::REG_RANGE_MIN: range_min_reg <= cfg_data;
                tprs_pkg::REG_RANGE_MAX: range_max_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    tprs_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .in_vld  (s_tvalid),
        .pix     (s_tdata[tprs_pkg::PIXEL_BITS-1:0]),
        .lo      (range_min_reg[tprs_pkg::PIXEL_BITS-1:0]),
        .hi      (range_max_reg[tprs_pkg::PIXEL_BITS-1:0]),
        .dout    (chain[0])
    );

    for (genvar i = 0; i < tprs_pkg::N_CELLS; i++) begin : g_cell
        tprs_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (adv),
            .din     (chain[i]),
            .dout    (chain[i+1])
        );
    end

    // top quotient bit set means the quotient passed 255
    assign m_data_next = chain[tprs_pkg::N_CELLS].q[tprs_pkg::Q_W-1]
                         ? '1 : chain[tprs_pkg::N_CELLS].q[tprs_pkg::OUT_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else if (adv) begin
            m_vld_reg <= chain[tprs_pkg::N_CELLS].vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = m_data_reg;

endmodule

/* rtl/tprs_checker.sv */
module tprs_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        cfg_ready
);

    // a held result keeps its data
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // input side opens exactly when the output register can move
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready out of step with output stall");

    // no result straight out of reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind thermal_pixel_range_scaler tprs_checker u_tprs_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_ready (cfg_ready)
);

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;

    localparam int LATENCY    = 12;
    localparam int CYCLE_CAP  = 400000;
    localparam int SEGMENTS   = 16;
    localparam int SEG_PIXELS = 25;
    localparam int FULL_SCALE = 255;
    // indexes the block does not decode, writes there must change nothing
    localparam logic [tprs_pkg::CFG_IDX_W-1:0] REG_SPARE =
        tprs_pkg::CFG_IDX_W'(tprs_pkg::REG_RANGE_MAX + 1);
    localparam logic [tprs_pkg::CFG_IDX_W-1:0] REG_NONE  = '1;

    class pixel_scoreboard;
        logic [tprs_pkg::PIXEL_BITS-1:0] range_lo;
        logic [tprs_pkg::PIXEL_BITS-1:0] range_hi;
        logic [tprs_pkg::OUT_BITS-1:0]   scaled_due[$];
        int                              errors;
        int                              pixels;
        int                              results;
        int                              reg_writes;

        function new();
            range_lo   = '0;
            range_hi   = '1;
            errors     = 0;
            pixels     = 0;
            results    = 0;
            reg_writes = 0;
        endfunction

        function void write_reg(logic [tprs_pkg::CFG_IDX_W-1:0] idx,
                                logic [tprs_pkg::CFG_DATA_W-1:0] data);
            reg_writes++;
            case (idx)
                tprs_pkg::REG_RANGE_MIN: range_lo = data[tprs_pkg::PIXEL_BITS-1:0];
                tprs_pkg::REG_RANGE_MAX: range_hi = data[tprs_pkg::PIXEL_BITS-1:0];
                default: ;
            endcase
        endfunction

        function logic [tprs_pkg::OUT_BITS-1:0] scale(logic [15:0] raw);
            bit [31:0] mask;
            bit [31:0] pix;
            bit [31:0] lo;
            bit [31:0] hi;
            bit [31:0] span;
            bit [31:0] quo;
            mask = (32'd1 << tprs_pkg::PIXEL_BITS) - 1;
            pix  = 32'(raw) & mask;
            lo   = 32'(range_lo) & mask;
            hi   = 32'(range_hi) & mask;
            if (hi < lo || pix <= lo)
                return '0;
            span = hi - lo;
            if (span == 0)
                span = 1;
            quo = ((pix - lo) * FULL_SCALE) / span;
            if (quo > FULL_SCALE)
                quo = FULL_SCALE;
            return quo[tprs_pkg::OUT_BITS-1:0];
        endfunction

        function void note_pixel(logic [15:0] raw);
            pixels++;
            scaled_due.push_back(scale(raw));
        endfunction

        function void check_scaled(logic [tprs_pkg::OUT_BITS-1:0] got);
            logic [tprs_pkg::OUT_BITS-1:0] want;
            results++;
            if (scaled_due.size() == 0) begin
                $error("scaled_pixel %0d arrived with no pixel outstanding", got);
                errors++;
            end else begin
                want = scaled_due.pop_front();
                if (got !== want) begin
                    $error("scaled_pixel mismatch: expected %0d, actual %0d", want, got);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return scaled_due.size();
        endfunction

        function void close_out();
            if (scaled_due.size() != 0) begin
                $error("%0d scaled_pixel results never arrived", scaled_due.size());
                errors += scaled_due.size();
            end
        endfunction
    endclass

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [15:0]                     s_tdata   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [7:0]                      m_tdata;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [tprs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [tprs_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    pixel_scoreboard board;
    int              src_idle_pct  = 0;
    int              snk_stall_pct = 0;
    int              cycles        = 0;

    thermal_pixel_range_scaler u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // every transfer is seen here with pre-edge values
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                board.write_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                board.note_pixel(s_tdata);
            if (m_tvalid && m_tready)
                board.check_scaled(m_tdata);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_pixel(input logic [15:0] raw);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= raw;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (board.pending() != 0);
    endtask

    task automatic write_reg(input logic [tprs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_range(input logic [15:0] lo, input logic [15:0] hi);
        if ($urandom_range(1)) begin
            write_reg(tprs_pkg::REG_RANGE_MIN, lo);
            write_reg(tprs_pkg::REG_RANGE_MAX, hi);
        end else begin
            write_reg(tprs_pkg::REG_RANGE_MAX, hi);
            write_reg(tprs_pkg::REG_RANGE_MIN, lo);
        end
    endtask

    function automatic logic [15:0] pick_pixel(logic [15:0] lo, logic [15:0] hi);
        logic [15:0] a;
        logic [15:0] b;
        int          roll;
        a    = (lo < hi) ? lo : hi;
        b    = (lo < hi) ? hi : lo;
        roll = $urandom_range(9);
        if (roll < 3)
            return 16'($urandom);
        if (roll == 3)
            return a + 16'($urandom_range(2)) - 16'd1;
        if (roll == 4)
            return b + 16'($urandom_range(2)) - 16'd1;
        return 16'($urandom_range(b, a));
    endfunction

    task automatic random_range(output logic [15:0] lo, output logic [15:0] hi);
        logic [15:0] t;
        lo = 16'($urandom);
        hi = 16'($urandom);
        case ($urandom_range(5))
            0: ;
            1: hi = lo + 16'($urandom_range(300));
            2: hi = lo;
            3: begin
                if (hi > lo) begin
                    t  = hi;
                    hi = lo;
                    lo = t;
                end
            end
            4: begin
                lo = $urandom_range(1) ? 16'hffff : 16'h0000;
                hi = $urandom_range(1) ? 16'hffff : 16'h0000;
            end
            default: begin
                lo = 16'($urandom_range(2000));
                hi = 16'hffff - 16'($urandom_range(2000));
            end
        endcase
    endtask

    initial begin
        logic [15:0] lo;
        logic [15:0] hi;
        board = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset range: full 16-bit span
        send_pixel(16'h0000);
        send_pixel(16'h0001);
        send_pixel(16'h0101);
        send_pixel(16'h5555);
        send_pixel(16'haaaa);
        send_pixel(16'hfffe);
        send_pixel(16'hffff);
        wait_idle();

        // ordinary window, edges and beyond
        set_range(16'd1000, 16'd2000);
        send_pixel(16'd999);
        send_pixel(16'd1000);
        send_pixel(16'd1001);
        send_pixel(16'd1500);
        send_pixel(16'd2000);
        send_pixel(16'd2001);
        wait_idle();

        // zero span saturates anything above the floor
        set_range(16'd3000, 16'd3000);
        send_pixel(16'd3000);
        send_pixel(16'd3001);
        wait_idle();

        // inverted window forces zero; undecoded indexes must not disturb it
        set_range(16'd5000, 16'd100);
        write_reg(REG_SPARE, 16'h0000);
        write_reg(REG_NONE, 16'hffff);
        send_pixel(16'd7000);
        send_pixel(16'hffff);
        wait_idle();

        set_range(16'hffff, 16'hffff);
        send_pixel(16'hffff);
        send_pixel(16'h0000);
        wait_idle();

        set_range(16'h0000, 16'h0000);
        send_pixel(16'h0000);
        send_pixel(16'h0001);
        send_pixel(16'hffff);
        wait_idle();

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            random_range(lo, hi);
            set_range(lo, hi);
            if ($urandom_range(3) == 0)
                write_reg($urandom_range(1) ? REG_NONE : REG_SPARE, 16'($urandom));
            case (seg % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 68; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 68; end
                default: begin src_idle_pct = 22; snk_stall_pct = 22; end
            endcase
            for (int i = 0; i < SEG_PIXELS; i++)
                send_pixel(pick_pixel(lo, hi));
            wait_idle();
        end

        snk_stall_pct = 0;
        repeat (LATENCY + 8) @(posedge aclk);
        board.close_out();
        $display("scaled %0d pixels, checked %0d results over %0d register writes",
                 board.pixels, board.results, board.reg_writes);
        $display("ranges covered: full, narrow, zero span, inverted and random windows");
        if (board.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* thermal_pixel_range_scaler.f */
rtl/tprs_pkg.sv
rtl/tprs_front.sv
rtl/tprs_cell.sv
rtl/thermal_pixel_range_scaler.sv
rtl/tprs_checker.sv
tb/tb.sv
